// ----- rtl/rmq_pkg.sv -----
// shared constants and types for the rotation matrix to quaternion converter
package rmq_pkg;

  localparam int QW = 16;
  localparam int RAD_W = 17;   // radicand, positive part only
  localparam int ROOT_W = 18;  // floor(sqrt(radicand * 2^18))
  localparam int MAG_W = 17;   // magnitude of an off-diagonal numerator, up to 2^16
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT = QW;
  localparam int SIDE_LEN = SQRT_LAT + DIV_LAT + 1;

  localparam logic signed [18:0] Q_ONE = 19'sd16384;
  localparam logic signed [QW-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [QW-1:0] Q_MIN = 16'sh8000;

  typedef logic [1:0] case_t;
  localparam case_t CASE_TRACE = 2'd0;
  localparam case_t CASE_X = 2'd1;
  localparam case_t CASE_Y = 2'd2;
  localparam case_t CASE_Z = 2'd3;

  typedef struct packed {
    case_t kase;
    logic zero;
    logic [3:0] neg;
    logic [3:0][MAG_W-1:0] mag;
  } side_t;

endpackage

// ----- rtl/rmq_isqrt.sv -----
// pipelined integer square root of radicand * 2^18, one result bit per stage
module rmq_isqrt (
  input  logic clk,
  input  logic en,
  input  logic [rmq_pkg::RAD_W-1:0] radicand,
  output logic [rmq_pkg::ROOT_W-1:0] root
);
  import rmq_pkg::*;

  localparam int V_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;

  logic [REM_W-1:0] rem_i [SQRT_LAT];
  logic [ROOT_W-1:0] root_i [SQRT_LAT];
  logic [V_W-1:0] v_i [SQRT_LAT];
  logic [REM_W-1:0] rem_q [SQRT_LAT];
  logic [ROOT_W-1:0] root_q [SQRT_LAT];
  logic [V_W-1:0] v_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [REM_W+1:0] rsh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic ge;

    if (k == 0) begin : g_first
      assign rem_i[k] = '0;
      assign root_i[k] = '0;
      assign v_i[k] = {1'b0, radicand, {(V_W-RAD_W-1){1'b0}}};
    end else begin : g_rest
      assign rem_i[k] = rem_q[k-1];
      assign root_i[k] = root_q[k-1];
      assign v_i[k] = v_q[k-1];
    end

    assign rsh = {rem_i[k], v_i[k][V_W-1 -: 2]};
    assign trial = {1'b0, root_i[k], 2'b01};
    assign ge = (rsh >= trial);
    assign diff = rsh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[REM_W-1:0] : rsh[REM_W-1:0];
        root_q[k] <= {root_i[k][ROOT_W-2:0], ge};
        v_q[k] <= {v_i[k][V_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQRT_LAT-1];

endmodule

// ----- rtl/rmq_div.sv -----
// pipelined rounded divide of mag * 2^15 by root, overflow check then 15 quotient bits
module rmq_div (
  input  logic clk,
  input  logic en,
  input  logic [rmq_pkg::MAG_W-1:0] mag,
  input  logic [rmq_pkg::ROOT_W-1:0] r,
  output logic ovf,
  output logic [rmq_pkg::QW-2:0] quo
);
  import rmq_pkg::*;

  localparam int QB = QW - 1;
  localparam int D_W = MAG_W + QB + 1;

  logic [D_W-1:0] d;
  logic [D_W:0] lim;

  logic ovf_q [DIV_LAT];
  logic [ROOT_W-1:0] rem_q [DIV_LAT];
  logic [ROOT_W-1:0] r_q [DIV_LAT];
  logic [QB-1:0] low_q [DIV_LAT];
  logic [QB-1:0] q_q [DIV_LAT];

  // add half the divisor for round to nearest
  assign d = {1'b0, mag, {QB{1'b0}}} + {{(D_W-ROOT_W+1){1'b0}}, r[ROOT_W-1:1]};
  assign lim = {{(D_W+1-ROOT_W-QB){1'b0}}, r, {QB{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= ({1'b0, d} >= lim);
      rem_q[0] <= d[D_W-1 -: ROOT_W];
      r_q[0] <= r;
      low_q[0] <= d[QB-1:0];
      q_q[0] <= '0;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
    logic [ROOT_W:0] rsh;
    logic [ROOT_W:0] diff;
    logic ge;

    assign rsh = {rem_q[k-1], low_q[k-1][QB-1]};
    assign ge = (rsh >= {1'b0, r_q[k-1]});
    assign diff = rsh - {1'b0, r_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[k] <= ovf_q[k-1];
        rem_q[k] <= ge ? diff[ROOT_W-1:0] : rsh[ROOT_W-1:0];
        r_q[k] <= r_q[k-1];
        low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
        q_q[k] <= {q_q[k-1][QB-2:0], ge};
      end
    end
  end

  assign ovf = ovf_q[DIV_LAT-1];
  assign quo = q_q[DIV_LAT-1];

endmodule

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// rotation matrix to quaternion converter, top level
//
// Input channel: in_valid/in_ready with the nine matrix elements m00..m22 in
// signed Q2.14. Output channel: out_valid/out_ready with quat_w..quat_z in
// signed Q2.14 (saturated) and case_taken.
// One item may enter every cycle while in_ready is high; each item gives
// exactly one result. From acceptance to out_valid an item passes the
// decode register (case, radicand and numerators), which loads at
// acceptance, then 18 square root stages (one root bit each), 16 divide
// stages (overflow check then one quotient bit each), and the output
// register. Throughput is one item per cycle while out_ready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; empty slots hold as well, and in_ready is high
// whenever out_valid is low or out_ready is high.
// A synchronous reset clears all valid bits; results in flight are dropped.
// A radicand that is not positive gives an all-zero quaternion with the
// selected case still reported.
module rotation_matrix_to_quaternion (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output rmq_pkg::case_t case_taken
);
  import rmq_pkg::*;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // decode
  logic signed [18:0] a00, a11, a22, t0, t1, t2, t3, t_sel;
  logic signed [16:0] d21, d02, d10, s01, s02, s12;
  logic signed [16:0] num [4];
  case_t kase_c;
  side_t dec_c;
  logic [RAD_W-1:0] rad_c;

  assign a00 = 19'(m00);
  assign a11 = 19'(m11);
  assign a22 = 19'(m22);
  assign t0 = a00 + a11 + a22 + Q_ONE;
  assign t1 = Q_ONE + a00 - a11 - a22;
  assign t2 = Q_ONE + a11 - a00 - a22;
  assign t3 = Q_ONE + a22 - a00 - a11;
  assign d21 = 17'(m21) - 17'(m12);
  assign d02 = 17'(m02) - 17'(m20);
  assign d10 = 17'(m10) - 17'(m01);
  assign s01 = 17'(m01) + 17'(m10);
  assign s02 = 17'(m02) + 17'(m20);
  assign s12 = 17'(m12) + 17'(m21);

  always_comb begin
    if (t0 > 19'sd0) kase_c = CASE_TRACE;
    else if (m00 > m11 && m00 > m22) kase_c = CASE_X;
    else if (m11 > m00 && m11 > m22) kase_c = CASE_Y;
    else kase_c = CASE_Z;
    num[0] = '0;
    num[1] = '0;
    num[2] = '0;
    num[3] = '0;
    case (kase_c)
      CASE_TRACE: begin
        t_sel = t0;
        num[1] = d21; num[2] = d02; num[3] = d10;
      end
      CASE_X: begin
        t_sel = t1;
        num[0] = d21; num[2] = s01; num[3] = s02;
      end
      CASE_Y: begin
        t_sel = t2;
        num[0] = d02; num[1] = s01; num[3] = s12;
      end
      default: begin
        t_sel = t3;
        num[0] = d10; num[1] = s02; num[2] = s12;
      end
    endcase
    dec_c.kase = kase_c;
    dec_c.zero = !(t_sel > 19'sd0);
    rad_c = dec_c.zero ? '0 : t_sel[RAD_W-1:0];
    for (int i = 0; i < 4; i++) begin
      dec_c.neg[i] = num[i][16];
      dec_c.mag[i] = num[i][16] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
    end
  end

  logic [SIDE_LEN-1:0] vld;
  side_t side [SIDE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SIDE_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= dec_c;
      for (int k = 1; k < SIDE_LEN; k++) side[k] <= side[k-1];
    end
  end

  logic [RAD_W-1:0] rad_q;
  logic [ROOT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (adv) rad_q <= rad_c;
  end

  rmq_isqrt u_sqrt (
    .clk(clk),
    .en(adv),
    .radicand(rad_q),
    .root(root)
  );

  // dominant component 0.5*sqrt rounded, carried alongside the divider
  logic [ROOT_W:0] dom_sum;
  logic [QW-1:0] dom_c;
  logic [QW-1:0] dom_q [DIV_LAT];

  assign dom_sum = {1'b0, root} + (ROOT_W+1)'(4);
  assign dom_c = dom_sum[ROOT_W:3] > (ROOT_W-2)'(Q_MAX) ? Q_MAX : dom_sum[3 +: QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      dom_q[0] <= dom_c;
      for (int k = 1; k < DIV_LAT; k++) dom_q[k] <= dom_q[k-1];
    end
  end

  logic ovf [4];
  logic [QW-2:0] quo [4];
  logic signed [QW-1:0] lane [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    rmq_div u_div (
      .clk(clk),
      .en(adv),
      .mag(side[SQRT_LAT].mag[i]),
      .r(root),
      .ovf(ovf[i]),
      .quo(quo[i])
    );

    always_comb begin
      if (side[SIDE_LEN-1].zero) lane[i] = '0;
      else if (side[SIDE_LEN-1].kase == case_t'(i)) lane[i] = dom_q[DIV_LAT-1];
      else if (ovf[i]) lane[i] = side[SIDE_LEN-1].neg[i] ? Q_MIN : Q_MAX;
      else if (side[SIDE_LEN-1].neg[i]) lane[i] = -$signed({1'b0, quo[i]});
      else lane[i] = $signed({1'b0, quo[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_w <= lane[0];
      quat_x <= lane[1];
      quat_y <= lane[2];
      quat_z <= lane[3];
      case_taken <= side[SIDE_LEN-1].kase;
    end
  end

`ifndef SYNTH
  a_ready: assert property (@(posedge clk) in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  a_trace_w: assert property (@(posedge clk) disable iff (rst)
      out_valid && case_taken == CASE_TRACE |-> quat_w > 16'sd0)
    else $error("trace case with non-positive w");
  a_empty: assert property (@(posedge clk) disable iff (rst)
      vld == '0 && !in_valid && out_ready |=> !out_valid)
    else $error("result from empty pipeline");
`endif

endmodule

// ----- test/rotation_matrix_to_quaternion_tb.sv -----
// testbench for the rotation matrix to quaternion converter
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int LATENCY = 35;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    case_t kase;
  } quat_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0;
  logic signed [15:0] m20 = 0, m21 = 0, m22 = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  case_t case_taken;

  quat_t expected_quats[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int case_seen[4];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  rotation_matrix_to_quaternion DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return Q_MAX;
    if (v < -32768) return Q_MIN;
    return v[15:0];
  endfunction

  // numerator * 2^15 / root, nearest, halves away from zero
  function automatic logic signed [15:0] scaled_quot(int n, longint r);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = ((mag << 15) + (r >> 1)) / r;
    return clamp16((n < 0) ? -q : q);
  endfunction

  function automatic quat_t convert_matrix(int a00, int a01, int a02, int a10,
                                           int a11, int a12, int a20, int a21,
                                           int a22);
    quat_t res;
    int num[4];
    logic signed [15:0] q[4];
    int t;
    longint r;
    num = '{0, 0, 0, 0};
    q = '{0, 0, 0, 0};
    t = a00 + a11 + a22 + 16384;
    if (t > 0) begin
      res.kase = CASE_TRACE;
      num[1] = a21 - a12; num[2] = a02 - a20; num[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      res.kase = CASE_X;
      t = 16384 + a00 - a11 - a22;
      num[0] = a21 - a12; num[2] = a01 + a10; num[3] = a02 + a20;
    end else if (a11 > a00 && a11 > a22) begin
      res.kase = CASE_Y;
      t = 16384 + a11 - a00 - a22;
      num[0] = a02 - a20; num[1] = a01 + a10; num[3] = a12 + a21;
    end else begin
      res.kase = CASE_Z;
      t = 16384 + a22 - a00 - a11;
      num[0] = a10 - a01; num[1] = a02 + a20; num[2] = a12 + a21;
    end
    if (t > 0) begin
      r = isqrt(64'(t) << 18);
      for (int i = 0; i < 4; i++)
        q[i] = (i == res.kase) ? clamp16((r + 4) >>> 3) : scaled_quot(num[i], r);
    end
    res.w = q[0]; res.x = q[1]; res.y = q[2]; res.z = q[3];
    return res;
  endfunction

  // valid stays up after the handshake; idle gaps and wait_drained drop it
  task automatic send_matrix(int a00, int a01, int a02, int a10, int a11,
                             int a12, int a20, int a21, int a22);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    m00 <= a00; m01 <= a01; m02 <= a02;
    m10 <= a10; m11 <= a11; m12 <= a12;
    m20 <= a20; m21 <= a21; m22 <= a22;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_quats.push_back(convert_matrix(16'(a00), 16'(a01), 16'(a02),
        16'(a10), 16'(a11), 16'(a12), 16'(a20), 16'(a21), 16'(a22)));
    n_items++;
  endtask

  function automatic int sext(int v);
    return int'($signed(16'(v)));
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n);
    int a[9];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) a[i] = sext($urandom());
      case ($urandom_range(3))
        // one diagonal element near 16384, every other element within +-8192
        0, 1: begin
          for (int i = 0; i < 9; i++) a[i] = sext($urandom_range(16384)) - 8192;
          a[4 * $urandom_range(2)] = 16384 - $urandom_range(200);
        end
        2: begin
          // negative trace region drives the diagonal cases
          a[0] = -$urandom_range(16384); a[4] = -$urandom_range(16384);
          a[8] = -$urandom_range(16384);
          a[4 * $urandom_range(2)] = $urandom_range(16384);
        end
        default: ;
      endcase
      send_matrix(a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]);
    end
  endtask

  task automatic test_directed();
    send_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    send_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    send_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    send_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    send_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
    send_matrix(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384);
    // full-scale elements, with ties on the diagonal
    send_matrix(-32768, 5, 6, 7, -32768, 8, 9, 10, -32768);
    send_matrix(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767);
    send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    // a tiny radicand saturates the quotients
    send_matrix(-16383, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
    send_matrix(-5000, 32767, 32767, 32767, -5000, 32767, 32767, 32767, -6385);
    send_matrix(-8192, 100, 200, 300, -8192, 400, 500, 600, -8192);
    send_matrix(-5461, 0, 0, 0, -5461, 0, 0, 0, -5462);
    send_matrix(-16384, 32767, -32768, 32767, -16384, -32768, 32767, -32768, 0);
    send_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(110);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 78; recv_stall_pct = 0;
    send_random(100);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; recv_stall_pct = 78;
    send_random(100);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 28; recv_stall_pct = 28;
    send_random(100);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1;
    send_random(60);
  endtask

  // long receiver hold-off so the pipeline fills and stalls the input
  always @(posedge clk) begin
    if (hold_off) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 300) hold_off <= 0;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d case=%0d", $time,
                 quat_w, quat_x, quat_y, quat_z, case_taken);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        n_results++;
        case_seen[e.kase]++;
        if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y || quat_z !== e.z ||
            case_taken !== e.kase) begin
          $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d case=%0d", $time,
                   e.w, e.x, e.y, e.z, e.kase);
          $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d case=%0d", $time,
                   quat_w, quat_x, quat_y, quat_z, case_taken);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_quats.size());
      $display("[rotation_matrix_to_quaternion] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_drained();
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d matrices converted; cases trace/x/y/z: %0d/%0d/%0d/%0d",
             n_results, case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
    if (errors == 0) $display("[rotation_matrix_to_quaternion] OK");
    else $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rmq_pkg.sv
rtl/rmq_isqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
